// ----- rtl/smt_pkg.sv -----
// shared types and constants for the sorted multiset table
`default_nettype none

package smt_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RES_W   = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } smt_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_APPLY
  } smt_state_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } smt_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/smt_cell.sv -----
// one cell of the sorted shift chain: holds one entry and compares it with the key
`default_nettype none

module smt_cell
  import smt_pkg::*;
(
  input  wire logic                      clk,
  input  wire smt_cmd_t                  cmd,
  input  wire logic signed [VALUE_W-1:0] key,
  input  wire logic                      occ,
  input  wire logic                      left_ge,
  input  wire logic signed [VALUE_W-1:0] left_val,
  input  wire logic signed [VALUE_W-1:0] right_val,
  output logic signed [VALUE_W-1:0]      entry,
  output logic                           ge,
  output logic                           eq
);

  logic signed [VALUE_W-1:0] entry_next;

  // free or not smaller than the key
  assign ge = !occ || (entry >= key);
  assign eq = occ && (entry == key);

  always_comb begin
    entry_next = entry;
    if (cmd.ins && ge) begin
      entry_next = left_ge ? left_val : key;
    end else if (cmd.rem && occ && ge) begin
      entry_next = right_val;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ----- rtl/smt_count_tree.sv -----
// pipelined population count of the per-cell match flags
`default_nettype none

module smt_count_tree #(
  parameter int unsigned N     = 16,
  parameter int unsigned CNT_W = 5
) (
  input  wire logic             clk,
  input  wire logic [N-1:0]     flags,
  output logic      [CNT_W-1:0] total
);

  localparam int unsigned LEVELS = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned P      = 1 << LEVELS;

  logic [CNT_W-1:0] node [1:2*P-1];

  genvar g;
  generate
    for (g = 0; g < P; g++) begin : g_leaf
      if (g < N) begin : g_used
        always_ff @(posedge clk) begin
          node[P+g] <= CNT_W'(flags[g]);
        end
      end else begin : g_pad
        always_ff @(posedge clk) begin
          node[P+g] <= '0;
        end
      end
    end
    for (g = 1; g < P; g++) begin : g_sum
      always_ff @(posedge clk) begin
        node[g] <= node[2*g] + node[2*g+1];
      end
    end
  endgenerate

  assign total = node[1];

endmodule

`default_nettype wire

// ----- rtl/sorted_multiset_table_top.sv -----
// top level of the sorted multiset table: control, shift chain and count tree
// request registered, matches counted in ST_COUNT, result registered in ST_APPLY
// one request at a time: in_ready is high only in ST_IDLE
// the result register lets the next request in while a result waits
// reset clears the entry count and control; cell contents are not cleared
`default_nettype none

module sorted_multiset_table_top
  import smt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                opcode,
  input  wire logic signed [VALUE_W-1:0] value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           ok,
  output logic [RES_W-1:0]               frequency,
  output logic [RES_W-1:0]               size,
  output logic                           empty_res
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned LEVELS = $clog2(CAPACITY);
  localparam int unsigned WAIT_W = $clog2(LEVELS + 2);

  smt_state_t                state, state_next;
  logic [WAIT_W-1:0]         wait_cnt, wait_cnt_next;
  logic [CNT_W-1:0]          entry_count, entry_count_next;
  logic [1:0]                cur_op;
  logic signed [VALUE_W-1:0] cur_value;

  smt_cmd_t                  cmd;
  logic                      commit;
  logic                      full;
  logic [CNT_W-1:0]          match_cnt;
  logic                      res_ok;
  logic [CNT_W-1:0]          res_freq;

  logic signed [VALUE_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]       cell_ge;
  logic [CAPACITY-1:0]       cell_eq;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      occ;
      logic                      lge;
      logic signed [VALUE_W-1:0] lval;
      logic signed [VALUE_W-1:0] rval;

      assign occ = CNT_W'(i) < entry_count;
      if (i == 0) begin : g_first
        assign lge  = 1'b0;
        assign lval = cur_value;
      end else begin : g_mid
        assign lge  = cell_ge[i-1];
        assign lval = cell_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign rval = cell_val[i];
      end else begin : g_inner
        assign rval = cell_val[i+1];
      end

      smt_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .key       (cur_value),
        .occ       (occ),
        .left_ge   (lge),
        .left_val  (lval),
        .right_val (rval),
        .entry     (cell_val[i]),
        .ge        (cell_ge[i]),
        .eq        (cell_eq[i])
      );
    end
  endgenerate

  smt_count_tree #(
    .N     (CAPACITY),
    .CNT_W (CNT_W)
  ) u_count (
    .clk   (clk),
    .flags (cell_eq),
    .total (match_cnt)
  );

  assign full     = entry_count == CNT_W'(CAPACITY);
  assign in_ready = state == ST_IDLE;
  assign commit   = (state == ST_APPLY) && (!out_valid || out_ready);

  // result and chain command for the request in hand
  always_comb begin
    cmd              = '0;
    res_ok           = 1'b0;
    res_freq         = match_cnt;
    entry_count_next = entry_count;
    unique case (cur_op)
      OP_INSERT: begin
        res_ok = !full;
        if (!full) begin
          res_freq         = match_cnt + CNT_W'(1);
          entry_count_next = entry_count + CNT_W'(1);
          cmd.ins          = commit;
        end
      end
      OP_REMOVE: begin
        res_ok = match_cnt != '0;
        if (match_cnt != '0) begin
          res_freq         = match_cnt - CNT_W'(1);
          entry_count_next = entry_count - CNT_W'(1);
          cmd.rem          = commit;
        end
      end
      default: begin
        res_ok = match_cnt != '0;
      end
    endcase
  end

  always_comb begin
    state_next    = state;
    wait_cnt_next = wait_cnt;
    unique case (state)
      ST_IDLE: begin
        wait_cnt_next = '0;
        if (in_valid) begin
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (wait_cnt == WAIT_W'(LEVELS)) begin
          state_next = ST_APPLY;
        end else begin
          wait_cnt_next = wait_cnt + WAIT_W'(1);
        end
      end
      ST_APPLY: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      wait_cnt    <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      wait_cnt <= wait_cnt_next;
      if (commit) begin
        entry_count <= entry_count_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_op    <= opcode;
      cur_value <= value;
    end
    if (commit) begin
      ok        <= res_ok;
      frequency <= RES_W'(res_freq);
      size      <= RES_W'(entry_count_next);
      empty_res <= entry_count_next == '0;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sorted_multiset_table_top_tb.sv -----
`timescale 1ns / 100ps
// testbench for sorted_multiset_table_top: directed and random requests against a predictor

module sorted_multiset_table_top_tb
  import smt_pkg::*;
();

  localparam int unsigned CAPACITY     = 16;
  localparam logic [1:0]  OP_SPARE     = 2'd3;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned PHASE_ITEMS  = 300;

  typedef logic signed [VALUE_W-1:0] entry_t;

  localparam entry_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam entry_t VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct packed {
    logic             ok;
    logic [RES_W-1:0] frequency;
    logic [RES_W-1:0] size;
    logic             empty_res;
  } table_result_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [1:0]       opcode    = OP_QUERY;
  entry_t           value     = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             ok;
  logic [RES_W-1:0] frequency;
  logic [RES_W-1:0] size;
  logic             empty_res;

  entry_t        held_vals[$];
  table_result_t pending_results[$];
  entry_t        value_pool[8];
  int unsigned   errors         = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  logic          receiver_hold  = 1'b0;
  event          hold_go;

  sorted_multiset_table_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ok       (ok),
    .frequency(frequency),
    .size     (size),
    .empty_res(empty_res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned count_matches(entry_t v);
    int unsigned n = 0;
    foreach (held_vals[i]) begin
      if (held_vals[i] == v) n++;
    end
    return n;
  endfunction

  // updates the held multiset and returns the result the request should produce
  function automatic table_result_t apply_request(logic [1:0] op, entry_t v);
    table_result_t r;
    int            pos;
    r.ok = 1'b0;
    if (op == OP_INSERT) begin
      if (held_vals.size() < CAPACITY) begin
        pos = 0;
        while (pos < held_vals.size() && held_vals[pos] < v) pos++;
        held_vals.insert(pos, v);
        r.ok = 1'b1;
      end
    end else if (op == OP_REMOVE) begin
      pos = 0;
      while (pos < held_vals.size() && held_vals[pos] != v) pos++;
      if (pos < held_vals.size()) begin
        held_vals.delete(pos);
        r.ok = 1'b1;
      end
    end else begin
      r.ok = count_matches(v) != 0;
    end
    r.frequency = RES_W'(count_matches(v));
    r.size      = RES_W'(held_vals.size());
    r.empty_res = held_vals.size() == 0;
    return r;
  endfunction

  function automatic entry_t pick_value();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return $urandom_range(1) ? VALUE_MIN : VALUE_MAX;
      3, 4, 5: return int'($urandom_range(8)) - 4;
      default: return value_pool[$urandom_range(7)];
    endcase
  endfunction

  task automatic send_request(input logic [1:0] op, input entry_t v);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_request(op, v));
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // grow and shrink regimes alternate so the table swings between empty and full
  task automatic send_random(input int unsigned n);
    logic [1:0]  op;
    entry_t      v;
    int unsigned grow_pct;
    int unsigned r;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    for (int unsigned k = 0; k < n; k++) begin
      grow_pct = ((k / 40) % 2 == 0) ? 75 : 20;
      r = $urandom_range(99);
      if (r < 10) op = $urandom_range(1) ? OP_QUERY : OP_SPARE;
      else if (r < 10 + grow_pct * 9 / 10) op = OP_INSERT;
      else op = OP_REMOVE;
      if (held_vals.size() != 0 && $urandom_range(2) != 0 &&
          (op != OP_INSERT || $urandom_range(1) == 0))
        v = held_vals[$urandom_range(held_vals.size() - 1)];
      else
        v = pick_value();
      send_request(op, v);
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (ok !== want.ok) begin
          $error("ok mismatch: expected %0d, actual %0d", want.ok, ok);
          errors++;
        end
        if (frequency !== want.frequency) begin
          $error("frequency mismatch: expected %0d, actual %0d", want.frequency, frequency);
          errors++;
        end
        if (size !== want.size) begin
          $error("size mismatch: expected %0d, actual %0d", want.size, size);
          errors++;
        end
        if (empty_res !== want.empty_res) begin
          $error("empty_res mismatch: expected %0d, actual %0d", want.empty_res, empty_res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always begin
    @(hold_go);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  task automatic test_empty_table();
    send_request(OP_QUERY, 0);
    send_request(OP_REMOVE, 5);
    send_request(OP_SPARE, -1);
  endtask

  task automatic test_extreme_values();
    send_request(OP_INSERT, VALUE_MAX);
    send_request(OP_INSERT, VALUE_MIN);
    // duplicate of the smallest entry goes first
    send_request(OP_INSERT, VALUE_MIN);
    send_request(OP_INSERT, -1);
    send_request(OP_QUERY, VALUE_MIN);
    send_request(OP_SPARE, VALUE_MAX);
  endtask

  task automatic test_full_table();
    int k = 0;
    while (held_vals.size() < CAPACITY) begin
      send_request(OP_INSERT, (k % 4) * 1000 - 1500);
      k++;
    end
    send_request(OP_INSERT, 0);
    send_request(OP_REMOVE, 12345);
    send_request(OP_REMOVE, VALUE_MIN);
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 0;  recv_stall_pct = 0;
    send_random(PHASE_ITEMS);
    send_idle_pct = 86; recv_stall_pct = 0;
    send_random(PHASE_ITEMS);
    send_idle_pct = 0;  recv_stall_pct = 86;
    send_random(PHASE_ITEMS);
    send_idle_pct = 23; recv_stall_pct = 23;
    send_random(PHASE_ITEMS);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_go;
    send_random(16);
    pause_sender();
    send_random(16);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_extreme_values();
    test_full_table();
    test_random_traffic();
    test_backpressure();
    pause_sender();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
